// ===== sv/pct_pkg.sv =====
// ----------------------------------------------------------------------------
// Prescaled compare timer package
// Shared types, register offsets, command and error codes.
// ----------------------------------------------------------------------------
package pct_pkg;

    // Prescale accumulator and divider widths.
    localparam int ACC_BITS  = 11;
    localparam int DIV_BITS  = 10;
    localparam int CTL_BITS  = 2;
    localparam int STEP_BITS = $clog2(ACC_BITS + 1);

    // Commands.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_LENGTH   = 2'd1;
    localparam logic [1:0] ERR_ALIGN    = 2'd2;
    localparam logic [1:0] ERR_RANGE    = 2'd3;

    localparam logic [3:0] ACCESS_BYTES = 4'd4;
    localparam logic [5:0] MAP_BYTES    = 6'd24;

    // Register word indexes (byte offset / 4).
    localparam logic [3:0] REG_CONTROL = 4'd0;
    localparam logic [3:0] REG_DIVIDER = 4'd1;
    localparam logic [3:0] REG_CNT_LO  = 4'd2;
    localparam logic [3:0] REG_CNT_HI  = 4'd3;
    localparam logic [3:0] REG_CMP_LO  = 4'd4;
    localparam logic [3:0] REG_CMP_HI  = 4'd5;

    // Control register bits.
    localparam int CTL_ENABLE = 0;
    localparam int CTL_SOURCE = 1;
    localparam logic [CTL_BITS-1:0] CTL_RESET = 2'b01;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  byte_addr;
        logic [3:0]  access_bytes;
        logic [31:0] write_data;
        logic [7:0]  instr_ticks;
        logic [7:0]  usec_ticks;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  error_code;
        logic        irq_level;
    } rsp_t;

    typedef struct packed {
        logic                done;
        logic [ACC_BITS-1:0] quotient;
        logic [ACC_BITS-1:0] remainder;
    } div_result_t;

endpackage

// ===== sv/pct_divider.sv =====
// ----------------------------------------------------------------------------
// Prescaler divider
// Restoring divider, one quotient bit per cycle, ACC_BITS quotient bits per divide.
// ----------------------------------------------------------------------------
module pct_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pct_pkg::ACC_BITS-1:0] dividend,
    input  logic [pct_pkg::ACC_BITS-1:0] divisor,
    output pct_pkg::div_result_t         result
);

    localparam int W = pct_pkg::ACC_BITS;

    logic [W-1:0]                  quo_reg;
    logic [W-1:0]                  quo_next;
    logic [W-1:0]                  rem_reg;
    logic [W-1:0]                  rem_next;
    logic [W-1:0]                  divisor_reg;
    logic [pct_pkg::STEP_BITS-1:0] step_reg;
    logic [pct_pkg::STEP_BITS-1:0] step_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [W-1:0]                  trial;
    logic                          fits;

    // The partial remainder stays below the divisor, so its top bit is free
    // to take the next dividend bit.
    assign trial = {rem_reg[W-2:0], quo_reg[W-1]};
    assign fits  = (trial >= divisor_reg);

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = pct_pkg::STEP_BITS'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (trial - divisor_reg) : trial;
            quo_next  = {quo_reg[W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == pct_pkg::STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

// ===== sv/prescaled_compare_timer.sv =====
// ----------------------------------------------------------------------------
// Prescaled compare timer
// Register-mapped timer with a divide-by-(divider+1) prescaler and a compare.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the req channel is a tick, a register read or a register
// write; each one produces exactly one transfer on the rsp channel with the
// read word, an error code and the interrupt level after the item.
// Both channels use valid/ready. The block takes one item at a time: req_ready
// is high only while the sequencer is idle.
// Sequence: a read, a write, a failed access or a disabled tick passes through
// the execute step and then the final step, which loads the output register and
// raises rsp_valid. An enabled tick starts the bit-serial divider in the execute
// step; the divider splits the prescale accumulator plus the tick amount by
// divider+1. Then come the counter add, the 64-bit compare and the load of the
// output register.
// The response sits in an output register, so a new request may be accepted
// while rsp waits; if rsp stalls, the next item waits in its final step
// until the register frees up.
// Reset: control = enabled with the instruction clock; divider, counter,
// compare, accumulator, pending flag and interrupt line all clear.
// ----------------------------------------------------------------------------
module prescaled_compare_timer #(
    parameter int COUNTER_BITS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pct_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pct_pkg::rsp_t  rsp
);

    localparam int ACC = pct_pkg::ACC_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    pct_pkg::req_t                   item_reg;

    logic [pct_pkg::CTL_BITS-1:0]    ctl_reg;
    logic [pct_pkg::CTL_BITS-1:0]    ctl_next;
    logic [pct_pkg::DIV_BITS-1:0]    divider_reg;
    logic [pct_pkg::DIV_BITS-1:0]    divider_next;
    logic [COUNTER_BITS-1:0]         counter_reg;
    logic [COUNTER_BITS-1:0]         counter_next;
    logic [63:0]                     compare_reg;
    logic [63:0]                     compare_next;
    logic [ACC-1:0]                  accum_reg;
    logic [ACC-1:0]                  accum_next;
    logic                            pending_reg;
    logic                            pending_next;
    logic                            irq_reg;
    logic                            irq_next;

    logic [31:0]                     rdata_reg;
    logic [31:0]                     rdata_next;
    logic [1:0]                      err_reg;
    logic [1:0]                      err_next;

    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    pct_pkg::rsp_t                   rsp_reg;
    logic                            rsp_load;

    logic                            div_start;
    logic [ACC-1:0]                  div_dividend;
    logic [ACC-1:0]                  div_divisor;
    pct_pkg::div_result_t            div_res;

    logic [1:0]                      access_err;
    logic [3:0]                      word_idx;
    logic [63:0]                     counter_wide;
    logic [7:0]                      tick_amount;
    logic                            accept;

    assign accept       = req_valid && req_ready;
    assign req_ready    = (state_reg == ST_IDLE);
    assign word_idx     = item_reg.byte_addr[5:2];
    assign counter_wide = 64'(counter_reg);
    assign tick_amount  = ctl_reg[pct_pkg::CTL_SOURCE] ? item_reg.usec_ticks
                                                       : item_reg.instr_ticks;
    assign div_dividend = accum_reg + ACC'(tick_amount);
    assign div_divisor  = ACC'(divider_reg) + 1'b1;
    assign rsp_load     = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready);

    // Length is checked first, then alignment, then the map bounds.
    always_comb
    begin
        priority if (item_reg.access_bytes != pct_pkg::ACCESS_BYTES)
        begin
            access_err = pct_pkg::ERR_LENGTH;
        end
        else if (item_reg.byte_addr[1:0] != 2'b00)
        begin
            access_err = pct_pkg::ERR_ALIGN;
        end
        else if (item_reg.byte_addr >= pct_pkg::MAP_BYTES)
        begin
            access_err = pct_pkg::ERR_RANGE;
        end
        else
        begin
            access_err = pct_pkg::ERR_OK;
        end
    end

    pct_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .result   (div_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        ctl_next     = ctl_reg;
        divider_next = divider_reg;
        counter_next = counter_reg;
        compare_next = compare_reg;
        accum_next   = accum_reg;
        pending_next = pending_reg;
        irq_next     = irq_reg;
        rdata_next   = rdata_reg;
        err_next     = err_reg;
        div_start    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                rdata_next = '0;
                err_next   = pct_pkg::ERR_OK;
                state_next = ST_DONE;
                if (item_reg.cmd == pct_pkg::CMD_TICK)
                begin
                    if (ctl_reg[pct_pkg::CTL_ENABLE])
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else if (item_reg.cmd == pct_pkg::CMD_READ ||
                         item_reg.cmd == pct_pkg::CMD_WRITE)
                begin
                    err_next = access_err;
                    if (access_err == pct_pkg::ERR_OK)
                    begin
                        if (item_reg.cmd == pct_pkg::CMD_READ)
                        begin
                            unique case (word_idx)
                                pct_pkg::REG_CONTROL: rdata_next = 32'(ctl_reg);
                                pct_pkg::REG_DIVIDER: rdata_next = 32'(divider_reg);
                                pct_pkg::REG_CNT_LO:  rdata_next = counter_wide[31:0];
                                pct_pkg::REG_CNT_HI:  rdata_next = counter_wide[63:32];
                                pct_pkg::REG_CMP_LO:  rdata_next = compare_reg[31:0];
                                default:              rdata_next = compare_reg[63:32];
                            endcase
                        end
                        else
                        begin
                            unique case (word_idx)
                                pct_pkg::REG_CONTROL:
                                begin
                                    ctl_next = item_reg.write_data[pct_pkg::CTL_BITS-1:0];
                                end
                                pct_pkg::REG_DIVIDER:
                                begin
                                    divider_next =
                                        item_reg.write_data[pct_pkg::DIV_BITS-1:0];
                                    counter_next = '0;
                                end
                                pct_pkg::REG_CNT_LO, pct_pkg::REG_CNT_HI:
                                begin
                                    counter_next = '0;
                                end
                                pct_pkg::REG_CMP_LO:
                                begin
                                    compare_next[31:0] = item_reg.write_data;
                                    pending_next       = 1'b0;
                                    irq_next           = 1'b0;
                                end
                                default:
                                begin
                                    compare_next[63:32] = item_reg.write_data;
                                    pending_next        = 1'b0;
                                    irq_next            = 1'b0;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    counter_next = counter_reg + COUNTER_BITS'(div_res.quotient);
                    accum_next   = div_res.remainder;
                    state_next   = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (counter_wide == compare_reg || pending_reg)
                begin
                    pending_next = 1'b1;
                    irq_next     = 1'b1;
                end
                else
                begin
                    irq_next = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ctl_reg       <= pct_pkg::CTL_RESET;
            divider_reg   <= '0;
            counter_reg   <= '0;
            compare_reg   <= '0;
            accum_reg     <= '0;
            pending_reg   <= 1'b0;
            irq_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctl_reg       <= ctl_next;
            divider_reg   <= divider_next;
            counter_reg   <= counter_next;
            compare_reg   <= compare_next;
            accum_reg     <= accum_next;
            pending_reg   <= pending_next;
            irq_reg       <= irq_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        rdata_reg <= rdata_next;
        err_reg   <= err_next;
        if (rsp_load)
        begin
            rsp_reg.read_data  <= rdata_reg;
            rsp_reg.error_code <= err_reg;
            rsp_reg.irq_level  <= irq_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The line is only raised together with the sticky flag and both clear
    // together, so they never disagree.
    assert property (@(posedge clk) disable iff (!rst_n) irq_reg == pending_reg)
        else $error("interrupt line and pending flag disagree");

    // The divider only reports completion while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    // A response only appears after the sequencer's final step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside the final step");

    // No new request is taken while a tick is in its divide or compare step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_CMP) |-> !req_ready)
        else $error("request accepted during a tick");

endmodule
